// ===== design/sm3_hash_engine_macros.svh =====
// assertion macros used by the checker file
`ifndef SM3_HASH_ENGINE_MACROS_SVH
`define SM3_HASH_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define SM3_ASSERT_IMP(lbl, ck, rn, ante, cons, txt) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(txt);

// next-cycle implication, disabled while reset is active
`define SM3_ASSERT_NXT(lbl, ck, rn, ante, cons, txt) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(txt);

`endif

// ===== design/sm3_pkg.sv =====
package sm3_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned Rounds = 64;
	localparam int unsigned DigestWords = 8;

	typedef logic [WordW-1:0] word_t;
	typedef logic [15:0][WordW-1:0] block_t;
	typedef logic [DigestWords-1:0][WordW-1:0] cv_t;

	// initial chaining value, word 0 at index 0
	localparam cv_t IV = {
		32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
		32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
	};

	localparam word_t T_LOW = 32'h79CC4519;
	localparam word_t T_HIGH = 32'h7A879D8A;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	// first byte of the 64-bit length field in a block
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [2:0] LAST_IDX = 3'(DigestWords - 1);

	// commands from the sequencer to the compression unit
	typedef struct packed {
		logic start;
		logic cv_init;
	} cmp_ctrl_t;

	// status back from the compression unit
	typedef struct packed {
		logic busy;
	} cmp_stat_t;

endpackage

// ===== design/sm3_ifs.sv =====
// message word channel
interface sm3_msg_if;
	logic valid;
	logic ready;
	logic [31:0] data_word;
	logic [2:0] byte_count;
	logic final_item;

	modport source (output valid, output data_word, output byte_count, output final_item,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input final_item,
		output ready);
endinterface

// digest word channel
interface sm3_dig_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

// ===== design/sm3_compress.sv =====
module sm3_round_unit (
	input logic clk,
	input logic arst_n,
	input sm3_pkg::cmp_ctrl_t ctrl,
	input sm3_pkg::block_t blk,
	output sm3_pkg::cmp_stat_t status,
	output sm3_pkg::cv_t cv
);

	function automatic sm3_pkg::word_t rol(sm3_pkg::word_t x, int unsigned n);
		return (x << n) | (x >> (sm3_pkg::WordW - n));
	endfunction

	function automatic sm3_pkg::word_t p0(sm3_pkg::word_t x);
		return x ^ rol(x, 9) ^ rol(x, 17);
	endfunction

	function automatic sm3_pkg::word_t p1(sm3_pkg::word_t x);
		return x ^ rol(x, 15) ^ rol(x, 23);
	endfunction

	// round constant rotated by j mod 32, folds into a small table
	function automatic sm3_pkg::word_t t_rot(logic [5:0] j);
		sm3_pkg::word_t base;
		logic [4:0] sh;
		base = (j[5:4] == 2'b00) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
		sh = j[4:0];
		return (base << sh) | (base >> (6'd32 - {1'b0, sh}));
	endfunction

	sm3_pkg::cv_t cv_q;
	sm3_pkg::cv_t v_q;
	sm3_pkg::cv_t v_nxt;
	sm3_pkg::block_t w_q;
	logic [5:0] round_q;
	logic busy_q;

	sm3_pkg::word_t a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
	logic early;

	// one round of the compression function
	always_comb begin
		early = (round_q[5:4] == 2'b00);
		a12 = rol(v_q[0], 12);
		ss1 = rol(a12 + v_q[4] + t_rot(round_q), 7);
		ss2 = ss1 ^ a12;
		if (early) begin
			ff = v_q[0] ^ v_q[1] ^ v_q[2];
			gg = v_q[4] ^ v_q[5] ^ v_q[6];
		end else begin
			ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
			gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
		end
		tt1 = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + v_q[7] + ss1 + w_q[0];
		v_nxt[0] = tt1;
		v_nxt[1] = v_q[0];
		v_nxt[2] = rol(v_q[1], 9);
		v_nxt[3] = v_q[2];
		v_nxt[4] = p0(tt2);
		v_nxt[5] = v_q[4];
		v_nxt[6] = rol(v_q[5], 19);
		v_nxt[7] = v_q[6];
		// message expansion, window holds W[j] .. W[j+15]
		w_new = p1(w_q[0] ^ w_q[7] ^ rol(w_q[13], 15)) ^ rol(w_q[3], 7) ^ w_q[10];
	end

	// round counter and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			round_q <= '0;
			cv_q <= sm3_pkg::IV;
		end else begin
			if (ctrl.cv_init) begin
				cv_q <= sm3_pkg::IV;
			end
			if (ctrl.start) begin
				busy_q <= 1'b1;
				round_q <= '0;
			end else if (busy_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'(sm3_pkg::Rounds - 1)) begin
					busy_q <= 1'b0;
					cv_q <= cv_q ^ v_nxt;
				end
			end
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			v_q <= cv_q;
			w_q <= blk;
		end else if (busy_q) begin
			v_q <= v_nxt;
			w_q <= {w_new, w_q[15:1]};
		end
	end

	assign status.busy = busy_q;
	assign cv = cv_q;

endmodule

// ===== design/sm3_hash_engine.sv =====
// SM3 hash engine, 256-bit digest.
// msg channel: one word per handshake, up to four message bytes packed from
// bits 31..24 down, byte_count valid bytes (5..7 count as 4), final_item on the
// last word of a message. Any word may be short; it may be empty.
// dig channel: eight digest words per message, word_index 0..7, last_word on 7.
// A non-final word that does not complete a 64-byte block leaves the engine ready
// for the next word. A word that completes a block holds the input while it is
// loaded (S_LOAD) and compressed in 64 rounds of the single round unit (S_WAIT).
// After a final word: a padding step (S_PAD), one or two compressions (two
// when the word fills the block, or when more than 55 bytes are left in it),
// then the digest is copied into the output buffer once that buffer is free;
// the first digest word shows the next cycle.
// The digest buffer decouples the two sides: a new message is taken while the
// digest words wait; a stall on dig only holds a later message's final copy.
// Reset loads the standard initial value and clears all byte and block counts.
module sm3_hash_engine (
	input logic clk,
	input logic arst_n,
	sm3_msg_if.sink msg,
	sm3_dig_if.source dig
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_PAD,
		S_LOAD_X,
		S_LOAD_F,
		S_WAIT,
		S_OUT
	} state_t;

	state_t state_q, after_q;
	logic fin_q;
	logic [31:0] dat_q;
	logic [2:0] cnt_q;
	logic [5:0] nold_q;
	logic [5:0] n_q;
	logic [54:0] blocks_q;
	logic out_busy_q;
	logic [2:0] idx_q;
	sm3_pkg::cv_t obuf_q;
	sm3_pkg::block_t buf_q;

	sm3_pkg::cmp_ctrl_t ctrl;
	sm3_pkg::cmp_stat_t status;
	sm3_pkg::cv_t cv;

	logic acc, dig_fire, copy;
	logic [2:0] cnt_in;
	logic [6:0] total;
	logic [63:0] bitlen;

	logic [5:0] wr_base;
	logic [31:0] wr_data;
	logic [2:0] wr_cnt;
	logic wr_phase, wr_on;
	logic [3:0] wr_en;
	logic [3:0][5:0] wr_pos;
	logic [3:0][7:0] wr_byte;

	sm3_round_unit u_cmp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.blk(buf_q),
		.status(status),
		.cv(cv)
	);

	// handshakes and counts
	assign msg.ready = (state_q == S_IDLE);
	assign acc = msg.valid && (state_q == S_IDLE);
	assign dig_fire = out_busy_q && dig.ready;
	assign copy = (state_q == S_OUT) && !out_busy_q;
	assign cnt_in = msg.byte_count[2] ? 3'd4 : msg.byte_count;
	assign total = {1'b0, n_q} + {4'b0000, cnt_in};
	assign bitlen = {blocks_q, n_q, 3'b000};

	// compression commands
	assign ctrl.start = (state_q == S_LOAD) || (state_q == S_LOAD_X) || (state_q == S_LOAD_F);
	assign ctrl.cv_init = copy;

	// byte lanes: bytes inside the current block on accept, spill bytes on load
	always_comb begin
		logic [6:0] p7;
		wr_phase = (state_q == S_LOAD);
		wr_on = acc || wr_phase;
		wr_base = wr_phase ? nold_q : n_q;
		wr_data = wr_phase ? dat_q : msg.data_word;
		wr_cnt = wr_phase ? cnt_q : cnt_in;
		for (int k = 0; k < 4; k++) begin
			p7 = {1'b0, wr_base} + 7'(k);
			wr_pos[k] = p7[5:0];
			wr_byte[k] = wr_data[8*(3-k) +: 8];
			wr_en[k] = wr_on && (3'(k) < wr_cnt) && (p7[6] == wr_phase);
		end
	end

	// block buffer
	always_ff @(posedge clk) begin
		case (state_q)
			S_PAD: begin
				for (int w = 0; w < 16; w++) begin
					// length words are filled below when they fit in this block
					if (w < 14 || n_q >= sm3_pkg::LEN_POS) begin
						for (int b = 0; b < 4; b++) begin
							if (6'(w*4 + b) == n_q) begin
								buf_q[w][8*(3-b) +: 8] <= sm3_pkg::PAD_BYTE;
							end else if (6'(w*4 + b) > n_q) begin
								buf_q[w][8*(3-b) +: 8] <= 8'h00;
							end
						end
					end
				end
				if (n_q < sm3_pkg::LEN_POS) begin
					buf_q[14] <= bitlen[63:32];
					buf_q[15] <= bitlen[31:0];
				end
			end
			S_LOAD_X: begin
				for (int w = 0; w < 14; w++) begin
					buf_q[w] <= '0;
				end
				buf_q[14] <= bitlen[63:32];
				buf_q[15] <= bitlen[31:0];
			end
			default: begin
				for (int k = 0; k < 4; k++) begin
					if (wr_en[k]) begin
						buf_q[wr_pos[k][5:2]][{~wr_pos[k][1:0], 3'b000} +: 8] <= wr_byte[k];
					end
				end
			end
		endcase
	end

	// sequencer and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= S_IDLE;
			fin_q <= 1'b0;
			dat_q <= '0;
			cnt_q <= '0;
			nold_q <= '0;
			n_q <= '0;
			blocks_q <= '0;
			out_busy_q <= 1'b0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						dat_q <= msg.data_word;
						cnt_q <= cnt_in;
						nold_q <= n_q;
						fin_q <= msg.final_item;
						n_q <= total[5:0];
						blocks_q <= blocks_q + 55'(total[6]);
						if (total[6]) begin
							state_q <= S_LOAD;
						end else if (msg.final_item) begin
							state_q <= S_PAD;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_WAIT;
					after_q <= fin_q ? S_PAD : S_IDLE;
				end
				S_PAD: begin
					state_q <= (n_q < sm3_pkg::LEN_POS) ? S_LOAD_F : S_LOAD_X;
				end
				S_LOAD_X: begin
					state_q <= S_WAIT;
					after_q <= S_LOAD_F;
				end
				S_LOAD_F: begin
					state_q <= S_WAIT;
					after_q <= S_OUT;
					n_q <= '0;
					blocks_q <= '0;
					fin_q <= 1'b0;
				end
				S_WAIT: begin
					if (!status.busy) begin
						state_q <= after_q;
					end
				end
				S_OUT: begin
					if (!out_busy_q) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// digest word sequencing
			if (copy) begin
				out_busy_q <= 1'b1;
				idx_q <= '0;
			end else if (dig_fire) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == sm3_pkg::LAST_IDX) begin
					out_busy_q <= 1'b0;
				end
			end
		end
	end

	// digest buffer, word 0 at the bottom
	always_ff @(posedge clk) begin
		if (copy) begin
			obuf_q <= cv;
		end else if (dig_fire) begin
			obuf_q <= obuf_q >> sm3_pkg::WordW;
		end
	end

	assign dig.valid = out_busy_q;
	assign dig.digest_word = obuf_q[0];
	assign dig.word_index = idx_q;
	assign dig.last_word = (idx_q == sm3_pkg::LAST_IDX);

endmodule

// ===== design/sm3_chk.sv =====
`include "sm3_hash_engine_macros.svh"

module sm3_chk (
	input logic clk,
	input logic arst_n,
	input logic msg_valid,
	input logic msg_ready,
	input logic msg_final,
	input logic dig_valid,
	input logic dig_ready,
	input logic [31:0] dig_word,
	input logic [2:0] dig_index,
	input logic dig_last
);

	// a stalled digest word stays offered
	`SM3_ASSERT_NXT(a_dig_hold, clk, arst_n, dig_valid && !dig_ready, dig_valid, "digest word dropped")

	// a stalled digest word keeps its value and position
	`SM3_ASSERT_NXT(a_dig_stable, clk, arst_n, dig_valid && !dig_ready, $stable(dig_word) && $stable(dig_index), "digest word changed while stalled")

	// digest words come back to back in index order
	`SM3_ASSERT_NXT(a_dig_order, clk, arst_n, dig_valid && dig_ready && !dig_last, dig_valid && (dig_index == $past(dig_index) + 3'd1), "digest word out of order")

	// the eighth word closes the digest
	`SM3_ASSERT_NXT(a_dig_end, clk, arst_n, dig_valid && dig_ready && dig_last, !dig_valid, "extra digest word")

	// a final message word starts padding, no word is taken right after it
	`SM3_ASSERT_IMP(a_msg_pad, clk, arst_n, $past(msg_valid && msg_ready && msg_final), !msg_ready, "word taken during padding")

endmodule

bind sm3_hash_engine sm3_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.msg_valid(msg.valid),
	.msg_ready(msg.ready),
	.msg_final(msg.final_item),
	.dig_valid(dig.valid),
	.dig_ready(dig.ready),
	.dig_word(dig.digest_word),
	.dig_index(dig.word_index),
	.dig_last(dig.last_word)
);

// ===== tb/tb_sm3_hash_engine.sv =====
`timescale 1ns / 1ps

module tb_sm3_hash_engine;
	import sm3_pkg::*;

	// one expected digest word
	typedef struct {
		word_t w;
		logic [2:0] idx;
		logic last;
	} digest_t;

	// sm3 predictor and store of expected digest words
	class digest_tracker;
		word_t cv[8];
		word_t blk[16];
		int unsigned fill;
		logic [54:0] blocks;
		digest_t digest_q[$];
		int unsigned errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) cv[i] = IV[i];
			for (int i = 0; i < 16; i++) blk[i] = '0;
			fill = 0;
			blocks = '0;
		endfunction

		function word_t rotl(word_t x, int unsigned n);
			n = n % 32;
			return (x << n) | (x >> (32 - n));
		endfunction

		function word_t p0(word_t x);
			return x ^ rotl(x, 9) ^ rotl(x, 17);
		endfunction

		function word_t p1(word_t x);
			return x ^ rotl(x, 15) ^ rotl(x, 23);
		endfunction

		// 64 rounds over the current block into the chaining value
		function void compress();
			word_t w[68];
			word_t a, b, c, d, e, f, g, h;
			word_t tj, a12, ss1, ss2, ff, gg, tt1, tt2;
			for (int j = 0; j < 16; j++) w[j] = blk[j];
			for (int j = 16; j < 68; j++)
				w[j] = p1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
			a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
			e = cv[4]; f = cv[5]; g = cv[6]; h = cv[7];
			for (int j = 0; j < 64; j++) begin
				tj = (j < 16) ? T_LOW : T_HIGH;
				a12 = rotl(a, 12);
				ss1 = rotl(word_t'(a12 + e + rotl(tj, j)), 7);
				ss2 = ss1 ^ a12;
				if (j < 16) begin
					ff = a ^ b ^ c;
					gg = e ^ f ^ g;
				end else begin
					ff = (a & b) | (a & c) | (b & c);
					gg = (e & f) | (~e & g);
				end
				tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
				tt2 = gg + h + ss1 + w[j];
				d = c;
				c = rotl(b, 9);
				b = a;
				a = tt1;
				h = g;
				g = rotl(f, 19);
				f = e;
				e = p0(tt2);
			end
			cv[0] ^= a; cv[1] ^= b; cv[2] ^= c; cv[3] ^= d;
			cv[4] ^= e; cv[5] ^= f; cv[6] ^= g; cv[7] ^= h;
		endfunction

		function void put_byte(int unsigned pos, logic [7:0] v);
			blk[(pos >> 2) & 15][24 - 8 * (pos & 3) +: 8] = v;
		endfunction

		function void add_byte(logic [7:0] v);
			put_byte(fill, v);
			fill++;
			if (fill == 64) begin
				compress();
				blocks++;
				fill = 0;
			end
		endfunction

		// an accepted message word: absorb bytes, pad and emit on the final word
		function void take_word(word_t data, logic [2:0] cnt, logic fin);
			int unsigned n;
			logic [63:0] bitlen;
			n = (cnt > 4) ? 4 : cnt;
			for (int i = 0; i < n; i++) add_byte(data[31 - 8 * i -: 8]);
			if (!fin) return;
			n = fill;
			bitlen = {blocks, 9'b0} + (64'(n) << 3);
			put_byte(n, PAD_BYTE);
			for (int i = n + 1; i < 64; i++) put_byte(i, 8'h00);
			// no room for the length: spill into an extra block
			if (n + 9 > 64) begin
				compress();
				for (int i = 0; i < 14; i++) blk[i] = '0;
			end
			blk[14] = bitlen[63:32];
			blk[15] = bitlen[31:0];
			compress();
			for (int i = 0; i < 8; i++)
				digest_q.push_back('{cv[i], 3'(i), i == 7});
			restart();
		endfunction

		function void check_digest(word_t w, logic [2:0] idx, logic last);
			digest_t want;
			if (digest_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected digest word %h index %0d last %0b", w, idx, last);
				return;
			end
			want = digest_q.pop_front();
			if (w !== want.w || idx !== want.idx || last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
						want.w, want.idx, want.last, w, idx, last);
			end
		endfunction

		function int pending();
			return digest_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit steady;
	int unsigned items_sent;
	digest_tracker board;

	sm3_msg_if msg_ch ();
	sm3_dig_if dig_ch ();

	sm3_hash_engine i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg_ch),
		.dig(dig_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	// offer one message word, called at a falling edge, returns at a falling edge
	task automatic send_word(input word_t data, input logic [2:0] cnt, input logic fin);
		steady = items_sent >= 80 && items_sent < 140;
		while (!steady && $urandom_range(99) < 37) begin
			msg_ch.valid <= 1'b0;
			@(negedge clk);
		end
		msg_ch.valid <= 1'b1;
		msg_ch.data_word <= data;
		msg_ch.byte_count <= cnt;
		msg_ch.final_item <= fin;
		@(posedge clk);
		while (!msg_ch.ready) @(posedge clk);
		board.take_word(data, cnt, fin);
		items_sent++;
		@(negedge clk);
	endtask

	// digest receiver with random stalls and one long hold-off
	initial begin
		int unsigned got;
		bit held;
		got = 0;
		held = 0;
		dig_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			// hold off long enough for the engine to back up into its input
			if (!held && got >= 40) begin
				held = 1;
				dig_ch.ready <= 1'b0;
				repeat (1200) @(negedge clk);
			end
			dig_ch.ready <= steady || $urandom_range(99) >= 37;
			@(posedge clk);
			if (dig_ch.valid && dig_ch.ready) begin
				board.check_digest(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
				got++;
			end
		end
	end

	// reset, directed messages, random messages, drain
	initial begin
		int unsigned len;
		logic [2:0] cnt;
		board = new();
		items_sent = 0;
		steady = 0;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_word = '0;
		msg_ch.byte_count = '0;
		msg_ch.final_item = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty message
		send_word(32'h0000_0000, 3'd0, 1'b1);
		// "abc"
		send_word(32'h6162_6300, 3'd3, 1'b1);
		// byte counts above four, all-ones and all-zeros words
		send_word(32'hFFFF_FFFF, 3'd7, 1'b0);
		send_word(32'h0000_0000, 3'd5, 1'b0);
		send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
		// short words in the middle of a message
		send_word(32'hA5A5_A5A5, 3'd1, 1'b0);
		send_word(32'h5A5A_5A5A, 3'd2, 1'b0);
		send_word(32'h1234_5678, 3'd3, 1'b0);
		send_word(32'hDEAD_BEEF, 3'd4, 1'b1);
		// 56 bytes: length field spills into a second block
		for (int k = 0; k < 13; k++) send_word($urandom(), 3'd4, 1'b0);
		send_word($urandom(), 3'd4, 1'b1);

		// random messages, mostly full words with the odd short one
		while (items_sent < 210) begin
			len = $urandom_range(99);
			if (len < 60) len = $urandom_range(8, 0);
			else if (len < 90) len = $urandom_range(20, 9);
			else len = $urandom_range(40, 21);
			for (int k = 0; k < len; k++) begin
				cnt = ($urandom_range(99) < 80) ? 3'd4 : 3'($urandom_range(7, 0));
				send_word($urandom(), cnt, 1'b0);
			end
			send_word($urandom(), 3'($urandom_range(7, 0)), 1'b1);
		end
		msg_ch.valid <= 1'b0;

		// drain
		while (board.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/sm3_pkg.sv
design/sm3_ifs.sv
design/sm3_compress.sv
design/sm3_hash_engine.sv
design/sm3_chk.sv
tb/tb_sm3_hash_engine.sv
